/* sv/kpd_pkg.sv */
`timescale 1ns / 1ps

package kpd_pkg;

    localparam int KEY_COUNT         = 5;
    localparam int TICK_COUNTER_BITS = 16;

    localparam int KEY_AW   = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int CODE_W   = $clog2(KEY_COUNT + 1);
    localparam int TMO_CODE = KEY_COUNT;

    localparam int THR_W  = 16;
    localparam int IDLE_W = 32;
    localparam int CMP_W  = (TICK_COUNTER_BITS > THR_W) ? TICK_COUNTER_BITS : THR_W;

    // event queue: room for the tail of one tick plus one whole new tick
    localparam int MAX_EV          = KEY_COUNT + 1;
    localparam int EVQ_DEPTH       = 2 ** $clog2(2 * MAX_EV + 2);
    localparam int EVQ_AW          = $clog2(EVQ_DEPTH);
    localparam int EVQ_CW          = EVQ_AW + 1;
    localparam int EVQ_STALL_LEVEL = EVQ_DEPTH - 2 * MAX_EV;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_DELAY   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT = 3'd4;

    localparam logic [1:0] MODE_RELEASED = 2'd0;
    localparam logic [1:0] MODE_HELD     = 2'd1;
    localparam logic [1:0] MODE_REPEAT   = 2'd2;

    localparam int REC_W = 2 + TICK_COUNTER_BITS;

    typedef struct packed {
        logic              enable;
        logic [THR_W-1:0]  debounce;
        logic [THR_W-1:0]  hold_delay;
        logic [THR_W-1:0]  repeat_period;
        logic [IDLE_W-1:0] idle_timeout;
    } cfg_t;

    typedef struct packed {
        logic [1:0]                   mode;
        logic [TICK_COUNTER_BITS-1:0] ticks;
    } key_rec_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              rel;
        logic              flush;
        logic              last;
    } evt_t;

endpackage

/* sv/keypad_debounce_autorepeat.sv */
`timescale 1ns / 1ps

// channel | direction | handshake          | word
// in      | input     | in_valid/in_stall   | key_levels
// out     | output    | out_valid/out_stall | key_code, is_release, flush_pending, last_event
// cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// One key per cycle through the key state RAM (one read, one write port); ticks
// follow back to back while the queue has room, and a key result is written in
// the cycle after its read is issued.
// Events leave through a small queue, one word per cycle while out_stall is low.
// Reset clears control state; per-key valid bits stand in for clearing the RAM.
// in_stall is high while a tick is still being scanned or the queue lacks room
// for two ticks of events.

module keypad_debounce_autorepeat (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [kpd_pkg::KEY_COUNT-1:0]     key_levels,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [kpd_pkg::CODE_W-1:0]        key_code,
    output logic                              is_release,
    output logic                              flush_pending,
    output logic                              last_event,
    input  logic                              cfg_we,
    input  logic [kpd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [kpd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    kpd_pkg::cfg_t                cfg_reg, cfg_next;
    logic [1:0]                   push_cnt;
    kpd_pkg::evt_t [2:0]          push_data;
    kpd_pkg::evt_t                head;
    logic [kpd_pkg::EVQ_CW-1:0]   evq_count;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                kpd_pkg::REG_ENABLE:       cfg_next.enable        = cfg_data[0];
                kpd_pkg::REG_DEBOUNCE:     cfg_next.debounce      = cfg_data[kpd_pkg::THR_W-1:0];
                kpd_pkg::REG_HOLD_DELAY:   cfg_next.hold_delay    = cfg_data[kpd_pkg::THR_W-1:0];
                kpd_pkg::REG_REPEAT:       cfg_next.repeat_period = cfg_data[kpd_pkg::THR_W-1:0];
                kpd_pkg::REG_IDLE_TIMEOUT: cfg_next.idle_timeout  = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{enable: 1'b1, debounce: 16'd5, hold_delay: 16'd50,
                         repeat_period: 16'd10, idle_timeout: 32'd6000};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    kpd_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .key_levels (key_levels),
        .in_stall   (in_stall),
        .evq_count  (evq_count),
        .push_cnt   (push_cnt),
        .push_data  (push_data)
    );

    kpd_evq u_evq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cnt   (push_cnt),
        .push_data  (push_data),
        .pop        (out_valid && !out_stall),
        .head_valid (out_valid),
        .head       (head),
        .count      (evq_count)
    );

    assign key_code      = head.code;
    assign is_release    = head.rel;
    assign flush_pending = head.flush;
    assign last_event    = head.last;

    a_evq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        evq_count <= kpd_pkg::EVQ_CW'(kpd_pkg::EVQ_DEPTH))
        else $error("event queue overflow");

    a_flush_on_break: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (flush_pending == is_release))
        else $error("flush flag does not match break event");

    a_timeout_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (key_code == kpd_pkg::CODE_W'(kpd_pkg::TMO_CODE)))
            |-> (!is_release && last_event))
        else $error("timeout event is not a final make word");

    a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (push_cnt != 2'd0)
            |-> (evq_count + kpd_pkg::EVQ_CW'(push_cnt) <= kpd_pkg::EVQ_CW'(kpd_pkg::EVQ_DEPTH)))
        else $error("event push exceeds queue room");

endmodule

/* sv/kpd_ram.sv */
`timescale 1ns / 1ps

module kpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* sv/kpd_evq.sv */
`timescale 1ns / 1ps

module kpd_evq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [1:0]                  push_cnt,
    input  kpd_pkg::evt_t [2:0]         push_data,
    input  logic                        pop,
    output logic                        head_valid,
    output kpd_pkg::evt_t               head,
    output logic [kpd_pkg::EVQ_CW-1:0]  count
);

    kpd_pkg::evt_t                mem_reg [kpd_pkg::EVQ_DEPTH];
    logic [kpd_pkg::EVQ_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [kpd_pkg::EVQ_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [kpd_pkg::EVQ_CW-1:0]   count_reg, count_next;

    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign count      = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + kpd_pkg::EVQ_AW'(push_cnt);
        rd_ptr_next = rd_ptr_reg + kpd_pkg::EVQ_AW'(pop);
        count_next  = count_reg + kpd_pkg::EVQ_CW'(push_cnt) - kpd_pkg::EVQ_CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            if (j < int'(push_cnt))
            begin
                mem_reg[wr_ptr_reg + kpd_pkg::EVQ_AW'(j)] <= push_data[j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* sv/kpd_scan.sv */
`timescale 1ns / 1ps

module kpd_scan (
    input  logic                             clk,
    input  logic                             rst_n,
    input  kpd_pkg::cfg_t                    cfg,
    input  logic                             in_valid,
    input  logic [kpd_pkg::KEY_COUNT-1:0]    key_levels,
    output logic                             in_stall,
    input  logic [kpd_pkg::EVQ_CW-1:0]       evq_count,
    output logic [1:0]                       push_cnt,
    output kpd_pkg::evt_t [2:0]              push_data
);

    localparam logic [kpd_pkg::KEY_AW-1:0] LAST_KEY = kpd_pkg::KEY_AW'(kpd_pkg::KEY_COUNT - 1);
    localparam logic [kpd_pkg::TICK_COUNTER_BITS-1:0] TICK_MAX = '1;
    localparam logic [kpd_pkg::IDLE_W-1:0] IDLE_MAX = '1;

    // read stage
    logic                            s1_valid_reg, s1_valid_next;
    logic [kpd_pkg::KEY_AW-1:0]      s1_idx_reg, s1_idx_next;
    logic [kpd_pkg::KEY_COUNT-1:0]   s1_levels_reg, s1_levels_next;

    // update stage
    logic                            s2_valid_reg, s2_valid_next;
    logic [kpd_pkg::KEY_AW-1:0]      s2_idx_reg, s2_idx_next;
    logic                            s2_pressed_reg, s2_pressed_next;
    logic                            s2_last_reg, s2_last_next;

    logic                            byp_hit_reg, byp_hit_next;
    kpd_pkg::key_rec_t               byp_data_reg, byp_data_next;
    logic [kpd_pkg::KEY_COUNT-1:0]   key_valid_reg, key_valid_next;

    logic                            pend_valid_reg, pend_valid_next;
    kpd_pkg::evt_t                   pend_reg, pend_next;
    logic                            tick_any_reg, tick_any_next;
    logic [kpd_pkg::IDLE_W-1:0]      idle_reg, idle_next;

    logic                            accept, start;
    logic [kpd_pkg::REC_W-1:0]       ram_rdata;
    kpd_pkg::key_rec_t               rec, rec_new;
    logic [kpd_pkg::TICK_COUNTER_BITS-1:0] ticks_inc;
    logic [kpd_pkg::CMP_W-1:0]       inc_ext;
    logic                            ev, ev_rel;
    kpd_pkg::evt_t                   ev_word, tmo_word;
    logic [kpd_pkg::IDLE_W-1:0]      idle_base, idle_inc;
    logic                            tmo;
    logic [1:0]                      n;

    assign in_stall = (s1_valid_reg && (s1_idx_reg != LAST_KEY))
                   || (evq_count > kpd_pkg::EVQ_CW'(kpd_pkg::EVQ_STALL_LEVEL));
    assign accept   = in_valid && !in_stall;
    assign start    = accept && cfg.enable;

    kpd_ram #(
        .WIDTH (kpd_pkg::REC_W),
        .DEPTH (kpd_pkg::KEY_COUNT)
    ) u_key_ram (
        .clk   (clk),
        .we    (s2_valid_reg),
        .waddr (s2_idx_reg),
        .wdata (rec_new),
        .re    (s1_valid_reg),
        .raddr (s1_idx_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        s1_valid_next  = 1'b0;
        s1_idx_next    = s1_idx_reg;
        s1_levels_next = s1_levels_reg;
        if (start)
        begin
            s1_valid_next  = 1'b1;
            s1_idx_next    = '0;
            s1_levels_next = key_levels;
        end
        else if (s1_valid_reg && (s1_idx_reg != LAST_KEY))
        begin
            s1_valid_next = 1'b1;
            s1_idx_next   = s1_idx_reg + 1'b1;
        end

        s2_valid_next   = s1_valid_reg;
        s2_idx_next     = s1_idx_reg;
        s2_pressed_next = s1_levels_reg[s1_idx_reg];
        s2_last_next    = (s1_idx_reg == LAST_KEY);

        // write to the entry being read in the same cycle: forward it
        byp_hit_next  = s1_valid_reg && s2_valid_reg && (s2_idx_reg == s1_idx_reg);
        byp_data_next = rec_new;
    end

    // key update
    always_comb
    begin
        if (byp_hit_reg)
        begin
            rec = byp_data_reg;
        end
        else if (key_valid_reg[s2_idx_reg])
        begin
            rec = kpd_pkg::key_rec_t'(ram_rdata);
        end
        else
        begin
            rec = '{mode: kpd_pkg::MODE_RELEASED, ticks: '0};
        end

        ticks_inc = (rec.ticks == TICK_MAX) ? rec.ticks : rec.ticks + 1'b1;
        inc_ext   = kpd_pkg::CMP_W'(ticks_inc);

        rec_new = rec;
        ev      = 1'b0;
        ev_rel  = 1'b0;
        if ((rec.mode != kpd_pkg::MODE_RELEASED) && !s2_pressed_reg)
        begin
            rec_new = '{mode: kpd_pkg::MODE_RELEASED, ticks: '0};
            ev      = 1'b1;
            ev_rel  = 1'b1;
        end
        else if ((rec.mode == kpd_pkg::MODE_RELEASED) && s2_pressed_reg)
        begin
            if (inc_ext >= kpd_pkg::CMP_W'(cfg.debounce))
            begin
                rec_new = '{mode: kpd_pkg::MODE_HELD, ticks: '0};
                ev      = 1'b1;
            end
            else
            begin
                rec_new.ticks = ticks_inc;
            end
        end
        else if (s2_pressed_reg)
        begin
            if (rec.mode == kpd_pkg::MODE_REPEAT)
            begin
                if (inc_ext >= kpd_pkg::CMP_W'(cfg.repeat_period))
                begin
                    rec_new.ticks = '0;
                    ev            = 1'b1;
                end
                else
                begin
                    rec_new.ticks = ticks_inc;
                end
            end
            else if (inc_ext >= kpd_pkg::CMP_W'(cfg.hold_delay))
            begin
                rec_new = '{mode: kpd_pkg::MODE_REPEAT, ticks: '0};
                ev      = 1'b1;
            end
            else
            begin
                rec_new.ticks = ticks_inc;
            end
        end
    end

    // idle counter and event ordering
    always_comb
    begin
        ev_word  = '{code: kpd_pkg::CODE_W'(s2_idx_reg), rel: ev_rel, flush: ev_rel,
                     last: 1'b0};
        tmo_word = '{code: kpd_pkg::CODE_W'(kpd_pkg::TMO_CODE), rel: 1'b0, flush: 1'b0,
                     last: 1'b1};

        idle_base = (tick_any_reg || ev) ? '0 : idle_reg;
        idle_inc  = (idle_base == IDLE_MAX) ? idle_base : idle_base + 1'b1;
        tmo       = (idle_inc >= cfg.idle_timeout);

        key_valid_next  = key_valid_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        tick_any_next   = tick_any_reg;
        idle_next       = idle_reg;
        push_data       = '0;
        n               = 2'd0;

        if (s2_valid_reg)
        begin
            key_valid_next[s2_idx_reg] = 1'b1;
            if (!s2_last_reg)
            begin
                tick_any_next = tick_any_reg || ev;
                if (ev)
                begin
                    if (pend_valid_reg)
                    begin
                        push_data[0] = pend_reg;
                        n            = 2'd1;
                    end
                    pend_valid_next = 1'b1;
                    pend_next       = ev_word;
                end
            end
            else
            begin
                tick_any_next   = 1'b0;
                pend_valid_next = 1'b0;
                idle_next       = tmo ? '0 : idle_inc;
                if (pend_valid_reg)
                begin
                    push_data[n] = pend_reg;
                    n            = n + 2'd1;
                end
                if (ev)
                begin
                    push_data[n] = ev_word;
                    n            = n + 2'd1;
                end
                if (tmo)
                begin
                    push_data[n] = tmo_word;
                    n            = n + 2'd1;
                end
                if (n != 2'd0)
                begin
                    push_data[n - 2'd1].last = 1'b1;
                end
            end
        end
        push_cnt = n;
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg     <= s1_idx_next;
        s1_levels_reg  <= s1_levels_next;
        s2_idx_reg     <= s2_idx_next;
        s2_pressed_reg <= s2_pressed_next;
        s2_last_reg    <= s2_last_next;
        byp_data_reg   <= byp_data_next;
        pend_reg       <= pend_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            byp_hit_reg    <= 1'b0;
            key_valid_reg  <= '0;
            pend_valid_reg <= 1'b0;
            tick_any_reg   <= 1'b0;
            idle_reg       <= '0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            s2_valid_reg   <= s2_valid_next;
            byp_hit_reg    <= byp_hit_next;
            key_valid_reg  <= key_valid_next;
            pend_valid_reg <= pend_valid_next;
            tick_any_reg   <= tick_any_next;
            idle_reg       <= idle_next;
        end
    end

endmodule
